// ===== sv/bpa_pkg.sv =====
// shared constants, codes and controller/datapath interface types
package bpa_pkg;

  // map geometry
  localparam int PAGE_TOTAL = 4096;
  localparam int MAP_BYTES  = PAGE_TOTAL / 8;
  localparam int BYTE_W     = $clog2(MAP_BYTES);
  localparam int PAGE_W     = $clog2(PAGE_TOTAL);
  localparam int IDX_W      = PAGE_W + 1;
  localparam int KB_W       = 15;
  localparam int REQ_W      = 25;
  localparam int CNT_W      = 13;
  localparam int RCNT_W     = 14;
  localparam int ADDR_W     = 24;
  localparam int KB_MAX     = 32767;
  localparam int DMA_LIMIT  = 64 * 1024;
  localparam int KB_PER_PAGE = 4;

  // command codes
  localparam logic [2:0] CMD_ALLOC_PAGE = 3'd0;
  localparam logic [2:0] CMD_ALLOC_RUN  = 3'd1;
  localparam logic [2:0] CMD_FREE       = 3'd2;
  localparam logic [2:0] CMD_RESERVE    = 3'd3;
  localparam logic [2:0] CMD_CLEAR      = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_MEM  = 2'd1;
  localparam logic [1:0] ST_DMA_BIG = 2'd2;
  localparam logic [1:0] ST_NO_FIT  = 2'd3;

  // datapath operations
  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_FAIL,
    OP_INIT_CLR,
    OP_CLR_WR,
    OP_INIT_A1,
    OP_A1_NEXT,
    OP_A1_TAKE,
    OP_INIT_FR,
    OP_FR_WR,
    OP_RD_PTR,
    OP_RD_IDX,
    OP_R_INIT,
    OP_R_SKIPBYTE,
    OP_R_GROUP,
    OP_R_INC,
    OP_R_START,
    OP_R_RESTART,
    OP_R_SET
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] st;
  } bpa_ctl_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       kb_lt4;
    logic       kb_lt_req;
    logic       dma_big;
    logic       req_zero;
    logic       cnt_zero;
    logic       dma;
    logic       clr_last;
    logic       a1_last;
    logic       hit_ptr;
    logic       hit_idx;
    logic       byte_full;
    logic       page_used;
    logic       idx_end;
    logic       idx_lastbyte;
    logic       idx_lastpage;
    logic       run_full;
    logic       dma_ok;
    logic       fr_last;
  } bpa_sts_t;

endpackage

// ===== sv/bpa_dpath.sv =====
// datapath: bitmap ram, scan pointers, counters and result registers
module bpa_dpath import bpa_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  bpa_ctl_t            ctl,
  input  logic [2:0]          in_cmd,
  input  logic [REQ_W-1:0]    in_request_bytes,
  input  logic                in_dma_only,
  input  logic [PAGE_W-1:0]   in_first_page,
  input  logic [CNT_W-1:0]    in_page_count,
  input  logic [KB_W-1:0]     in_init_free_kb,
  output bpa_sts_t            sts,
  output logic [1:0]          res_status,
  output logic [ADDR_W-1:0]   res_address,
  output logic [KB_W-1:0]     res_free_kb
);

  // bitmap memory
  logic [7:0] mem [MAP_BYTES];

  // captured transaction
  logic [2:0]        cmd_r;
  logic [REQ_W-1:0]  req_r;
  logic              dma_r;
  logic [PAGE_W-1:0] first_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [KB_W-1:0]   init_r;

  // working registers
  logic [BYTE_W-1:0] ptr_r;
  logic [BYTE_W-1:0] steps_r;
  logic [IDX_W-1:0]  idx_r;
  logic [PAGE_W-1:0] start_r;
  logic [BYTE_W-1:0] group_r;
  logic [RCNT_W-1:0] count_r;
  logic [PAGE_W-1:0] lo_r;
  logic [IDX_W-1:0]  hi_r;
  logic [KB_W-1:0]   free_kb_r;
  logic [BYTE_W-1:0] cached_r;
  logic [1:0]        status_r;
  logic [ADDR_W-1:0] addr_r;

  // read port
  logic [7:0]        rdata_r;
  logic [BYTE_W-1:0] rd_addr_r;
  logic              rd_ok_r;
  logic              re;
  logic [BYTE_W-1:0] ra;
  logic              we;
  logic [BYTE_W-1:0] wa;
  logic [7:0]        wd;

  // combinational helpers
  logic [2:0]        zero_pos;
  logic [7:0]        fr_mask;
  logic [7:0]        fr_byte;
  logic [3:0]        freed;
  logic [KB_W:0]     kb_add;
  logic [RCNT_W-1:0] count_calc;
  logic [REQ_W:0]    req_round;
  logic [RCNT_W-1:0] fr_sum;
  logic [IDX_W-1:0]  fr_hi;
  logic [IDX_W-1:0]  run_hi;
  logic [IDX_W-1:0]  hi_m1;
  logic [RCNT_W-1:0] run_len;
  logic [BYTE_W-1:0] grp_diff;
  logic [KB_W+1:0]   run_kb;
  logic [BYTE_W:0]   group_next;

  // lowest clear bit of the loaded byte
  always_comb begin
    zero_pos = 3'd0;
    for (int j = 7; j >= 0; j--) begin
      if (!rdata_r[j]) zero_pos = 3'(j);
    end
  end

  // page mask of the current byte inside the free/reserve range
  always_comb begin
    logic [PAGE_W-1:0] p;
    p = '0;
    for (int j = 0; j < 8; j++) begin
      p = {ptr_r, 3'(j)};
      fr_mask[j] = (p >= lo_r) && ({1'b0, p} < hi_r);
    end
  end

  assign fr_byte = (cmd_r == CMD_FREE) ? (rdata_r & ~fr_mask) : (rdata_r | fr_mask);
  assign freed   = 4'($countones(rdata_r & fr_mask));
  assign kb_add  = {1'b0, free_kb_r} + (KB_W+1)'({freed, 2'b00});

  // range ends and sizes
  assign req_round  = {1'b0, req_r} + (REQ_W+1)'(4095);
  assign count_calc = req_round[REQ_W:12];
  assign fr_sum     = RCNT_W'(first_r) + RCNT_W'(cnt_r);
  assign fr_hi      = (fr_sum > RCNT_W'(PAGE_TOTAL)) ? IDX_W'(PAGE_TOTAL) : fr_sum[IDX_W-1:0];
  assign run_hi     = IDX_W'(start_r) + count_r[IDX_W-1:0];
  assign hi_m1      = hi_r - IDX_W'(1);
  assign run_len    = RCNT_W'(idx_r) + RCNT_W'(1) - RCNT_W'(start_r);
  assign grp_diff   = idx_r[PAGE_W-1:3] - group_r;
  assign run_kb     = {count_r, 2'b00};
  assign group_next = {1'b0, group_r} + (BYTE_W+1)'(2);

  // status towards the controller
  always_comb begin
    sts.cmd          = cmd_r;
    sts.kb_lt4       = free_kb_r < KB_W'(KB_PER_PAGE);
    sts.kb_lt_req    = free_kb_r < req_r[REQ_W-1:10];
    sts.dma_big      = req_r > REQ_W'(DMA_LIMIT);
    sts.req_zero     = req_r == '0;
    sts.cnt_zero     = cnt_r == '0;
    sts.dma          = dma_r;
    sts.clr_last     = ptr_r == BYTE_W'(MAP_BYTES - 1);
    sts.a1_last      = steps_r == BYTE_W'(MAP_BYTES - 1);
    sts.hit_ptr      = rd_ok_r && (rd_addr_r == ptr_r);
    sts.hit_idx      = rd_ok_r && (rd_addr_r == idx_r[PAGE_W-1:3]);
    sts.byte_full    = rdata_r == 8'hFF;
    sts.page_used    = rdata_r[idx_r[2:0]];
    sts.idx_end      = idx_r[PAGE_W];
    sts.idx_lastbyte = idx_r[PAGE_W-1:3] == BYTE_W'(MAP_BYTES - 1);
    sts.idx_lastpage = idx_r == IDX_W'(PAGE_TOTAL - 1);
    sts.run_full     = run_len >= count_r;
    sts.dma_ok       = grp_diff <= BYTE_W'(1);
    sts.fr_last      = ptr_r == hi_m1[PAGE_W-1:3];
  end

  // memory port control
  always_comb begin
    re = 1'b0;
    ra = ptr_r;
    we = 1'b0;
    wa = ptr_r;
    wd = 8'h00;
    case (ctl.op)
      OP_RD_PTR: re = 1'b1;
      OP_RD_IDX: begin
        re = 1'b1;
        ra = idx_r[PAGE_W-1:3];
      end
      OP_CLR_WR: we = 1'b1;
      OP_A1_TAKE: begin
        we = 1'b1;
        wd = rdata_r | (8'h01 << zero_pos);
      end
      OP_FR_WR: begin
        we = 1'b1;
        wd = fr_byte;
      end
      default: ;
    endcase
  end

  // bitmap ram with registered read
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (re) begin
      rdata_r   <= mem[ra];
      rd_addr_r <= ra;
    end
  end

  // read data stays good until the next write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ok_r <= 1'b0;
    end else if (we) begin
      rd_ok_r <= 1'b0;
    end else if (re) begin
      rd_ok_r <= 1'b1;
    end
  end

  // control state: counters, cache and sweep pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r     <= '0;
      free_kb_r <= '0;
      cached_r  <= '0;
    end else begin
      case (ctl.op)
        OP_INIT_CLR: begin
          ptr_r     <= '0;
          cached_r  <= '0;
          free_kb_r <= init_r;
        end
        OP_CLR_WR: ptr_r <= ptr_r + BYTE_W'(1);
        OP_INIT_A1: ptr_r <= cached_r;
        OP_A1_NEXT: begin
          ptr_r <= (ptr_r == BYTE_W'(MAP_BYTES - 1)) ? '0 : ptr_r + BYTE_W'(1);
        end
        OP_A1_TAKE: begin
          cached_r  <= ptr_r;
          free_kb_r <= sts.kb_lt4 ? '0 : free_kb_r - KB_W'(KB_PER_PAGE);
        end
        OP_INIT_FR: begin
          ptr_r <= first_r[PAGE_W-1:3];
          if (cmd_r == CMD_FREE && first_r[PAGE_W-1:3] < cached_r) begin
            cached_r <= first_r[PAGE_W-1:3];
          end
        end
        OP_FR_WR: begin
          ptr_r <= ptr_r + BYTE_W'(1);
          if (cmd_r == CMD_FREE) begin
            free_kb_r <= (kb_add > (KB_W+1)'(KB_MAX)) ? KB_W'(KB_MAX) : kb_add[KB_W-1:0];
          end
        end
        OP_R_SET: begin
          ptr_r     <= start_r[PAGE_W-1:3];
          free_kb_r <= ((KB_W+2)'(free_kb_r) > run_kb) ?
                       KB_W'((KB_W+2)'(free_kb_r) - run_kb) : '0;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_LOAD: begin
        cmd_r    <= in_cmd;
        req_r    <= in_request_bytes;
        dma_r    <= in_dma_only;
        first_r  <= in_first_page;
        cnt_r    <= in_page_count;
        init_r   <= in_init_free_kb;
        status_r <= ST_OK;
        addr_r   <= '0;
      end
      OP_FAIL: status_r <= ctl.st;
      OP_INIT_A1: steps_r <= '0;
      OP_A1_NEXT: steps_r <= steps_r + BYTE_W'(1);
      OP_A1_TAKE: addr_r <= {ptr_r, zero_pos, 12'h000};
      OP_INIT_FR: begin
        lo_r <= first_r;
        hi_r <= fr_hi;
      end
      OP_R_INIT: begin
        idx_r   <= '0;
        count_r <= count_calc;
      end
      OP_R_SKIPBYTE: idx_r <= {1'b0, idx_r[PAGE_W-1:3] + BYTE_W'(1), 3'b000};
      OP_R_GROUP: group_r <= {idx_r[PAGE_W-1:4], 1'b0};
      OP_R_INC: idx_r <= idx_r + IDX_W'(1);
      OP_R_START: start_r <= idx_r[PAGE_W-1:0];
      OP_R_RESTART: idx_r <= {group_next, 3'b000};
      OP_R_SET: begin
        lo_r   <= start_r;
        hi_r   <= run_hi;
        addr_r <= {start_r, 12'h000};
      end
      default: ;
    endcase
  end

  assign res_status  = status_r;
  assign res_address = addr_r;
  assign res_free_kb = free_kb_r;

endmodule

// ===== sv/bpa_ctrl.sv =====
// controller: command sequencing state machine
module bpa_ctrl import bpa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  bpa_sts_t sts,
  output bpa_ctl_t ctl,
  output logic     busy,
  output logic     done
);

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DISP,
    S_CLEAR,
    S_A1,
    S_RPOS,
    S_RSKIP,
    S_RRUN,
    S_FR
  } state_t;

  state_t state_r, state_nxt;
  logic   done_r, done_nxt;

  // next state and datapath command
  always_comb begin
    state_nxt = state_r;
    done_nxt  = 1'b0;
    ctl.op    = OP_NOP;
    ctl.st    = ST_OK;
    unique case (state_r)
      S_INIT: begin
        ctl.op = OP_CLR_WR;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          ctl.op    = OP_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        state_nxt = S_IDLE;
        done_nxt  = 1'b1;
        case (sts.cmd) inside
          CMD_ALLOC_PAGE: begin
            if (sts.kb_lt4) begin
              ctl.op = OP_FAIL;
              ctl.st = ST_NO_MEM;
            end else begin
              ctl.op    = OP_INIT_A1;
              state_nxt = S_A1;
              done_nxt  = 1'b0;
            end
          end
          CMD_ALLOC_RUN: begin
            ctl.op = OP_FAIL;
            if (sts.kb_lt_req) begin
              ctl.st = ST_NO_MEM;
            end else if (sts.dma && sts.dma_big) begin
              ctl.st = ST_DMA_BIG;
            end else if (sts.req_zero) begin
              ctl.st = ST_NO_FIT;
            end else begin
              ctl.op    = OP_R_INIT;
              state_nxt = S_RPOS;
              done_nxt  = 1'b0;
            end
          end
          CMD_FREE, CMD_RESERVE: begin
            if (!sts.cnt_zero) begin
              ctl.op    = OP_INIT_FR;
              state_nxt = S_FR;
              done_nxt  = 1'b0;
            end
          end
          CMD_CLEAR: begin
            ctl.op    = OP_INIT_CLR;
            state_nxt = S_CLEAR;
            done_nxt  = 1'b0;
          end
          default: ;
        endcase
      end
      S_CLEAR: begin
        ctl.op = OP_CLR_WR;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
          done_nxt  = 1'b1;
        end
      end
      // single page: byte scan from the cached byte, one wrap
      S_A1: begin
        if (!sts.hit_ptr) begin
          ctl.op = OP_RD_PTR;
        end else if (!sts.byte_full) begin
          ctl.op    = OP_A1_TAKE;
          state_nxt = S_IDLE;
          done_nxt  = 1'b1;
        end else if (sts.a1_last) begin
          ctl.op    = OP_FAIL;
          ctl.st    = ST_NO_FIT;
          state_nxt = S_IDLE;
          done_nxt  = 1'b1;
        end else begin
          ctl.op = OP_A1_NEXT;
        end
      end
      // run search: skip full bytes, fix the group
      S_RPOS: begin
        if (sts.idx_end) begin
          ctl.op    = OP_FAIL;
          ctl.st    = ST_NO_FIT;
          state_nxt = S_IDLE;
          done_nxt  = 1'b1;
        end else if (!sts.hit_idx) begin
          ctl.op = OP_RD_IDX;
        end else if (sts.byte_full) begin
          if (sts.idx_lastbyte) begin
            ctl.op    = OP_FAIL;
            ctl.st    = ST_NO_FIT;
            state_nxt = S_IDLE;
            done_nxt  = 1'b1;
          end else begin
            ctl.op = OP_R_SKIPBYTE;
          end
        end else begin
          ctl.op    = OP_R_GROUP;
          state_nxt = S_RSKIP;
        end
      end
      // run search: skip used pages
      S_RSKIP: begin
        if (!sts.hit_idx) begin
          ctl.op = OP_RD_IDX;
        end else if (sts.page_used) begin
          if (sts.idx_lastpage) begin
            ctl.op    = OP_FAIL;
            ctl.st    = ST_NO_FIT;
            state_nxt = S_IDLE;
            done_nxt  = 1'b1;
          end else begin
            ctl.op = OP_R_INC;
          end
        end else begin
          ctl.op    = OP_R_START;
          state_nxt = S_RRUN;
        end
      end
      // run search: extend the run page by page
      S_RRUN: begin
        if (sts.idx_end) begin
          ctl.op    = OP_FAIL;
          ctl.st    = ST_NO_FIT;
          state_nxt = S_IDLE;
          done_nxt  = 1'b1;
        end else if (!sts.hit_idx) begin
          ctl.op = OP_RD_IDX;
        end else if (sts.page_used) begin
          state_nxt = S_RPOS;
        end else if (sts.run_full) begin
          if (!sts.dma || sts.dma_ok) begin
            ctl.op    = OP_R_SET;
            state_nxt = S_FR;
          end else begin
            ctl.op    = OP_R_RESTART;
            state_nxt = S_RPOS;
          end
        end else begin
          ctl.op = OP_R_INC;
        end
      end
      // range update, one bitmap byte per pass
      S_FR: begin
        if (!sts.hit_ptr) begin
          ctl.op = OP_RD_PTR;
        end else begin
          ctl.op = OP_FR_WR;
          if (sts.fr_last) begin
            state_nxt = S_IDLE;
            done_nxt  = 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  assign busy = state_r != S_IDLE;
  assign done = done_r;

endmodule

// ===== sv/bitmap_page_allocator.sv =====
// top level: bitmap page allocator, controller plus datapath
//
// One command is taken when start is high and busy is low; its single result
// appears on the out_ ports for exactly one cycle with out_valid high and must
// be taken then, as the receiver cannot stall. The bitmap sits in a single-port
// 512 x 8 RAM with registered read, and that port paces each command: a clear
// writes every bitmap byte; a single-page allocation reads bitmap bytes one by
// one from the cached byte; a free or reserve reads and rewrites each bitmap
// byte covered; a run allocation examines the map page by page (a short free
// stretch that ends on a used page costs a restart of the byte search) and
// loads bytes as it goes, then reads and rewrites each byte of the run to mark
// it. After reset the block runs a clearing pass over the bitmap and holds busy
// high until it is done.
module bitmap_page_allocator import bpa_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          in_cmd,
  input  logic [REQ_W-1:0]    in_request_bytes,
  input  logic                in_dma_only,
  input  logic [PAGE_W-1:0]   in_first_page,
  input  logic [CNT_W-1:0]    in_page_count,
  input  logic [KB_W-1:0]     in_init_free_kb,
  output logic                out_valid,
  output logic [1:0]          out_status,
  output logic [ADDR_W-1:0]   out_result_address,
  output logic [KB_W-1:0]     out_free_kb_now
);

  bpa_ctl_t ctl;
  bpa_sts_t sts;

  // sequencing
  bpa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy),
    .done  (out_valid)
  );

  // bitmap and arithmetic
  bpa_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .in_cmd           (in_cmd),
    .in_request_bytes (in_request_bytes),
    .in_dma_only      (in_dma_only),
    .in_first_page    (in_first_page),
    .in_page_count    (in_page_count),
    .in_init_free_kb  (in_init_free_kb),
    .sts              (sts),
    .res_status       (out_status),
    .res_address      (out_result_address),
    .res_free_kb      (out_free_kb_now)
  );

endmodule
